FILE: sv/sradix_pkg.sv
// ----------------------------------------------------------------------------
// sradix_pkg
// Shared types and constants for the signed radix to symbol converter.
// ----------------------------------------------------------------------------
package sradix_pkg;

    localparam int SYM_W       = 8;
    localparam int TBL_ENTRIES = 16;
    localparam int TBL_IDX_W   = 4;
    localparam int TBL_BITS    = TBL_ENTRIES * SYM_W;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 64;
    localparam int BASE_LEN_W  = 5;
    localparam int IN_W        = 32;
    localparam int DIV_CHUNK   = 8;

    localparam logic [SYM_W-1:0] PLUS_BYTE  = 8'h2B;
    localparam logic [SYM_W-1:0] MINUS_BYTE = 8'h2D;

    localparam logic [BASE_LEN_W-1:0] BASE_LEN_RESET = 5'd10;

    localparam logic [CFG_IDX_W-1:0] CFG_SYMBOLS_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYMBOLS_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_LEN     = 2'd2;

    typedef struct packed {
        logic load;
        logic chk_step;
        logic div_step;
        logic emit_sign;
        logic emit_digit;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
        logic chk_bad;
        logic chk_done;
        logic div_last;
        logic quo_zero;
        logic neg;
        logic last_digit;
    } t_dp_sts;

    function automatic logic [SYM_W-1:0] tbl_byte(
        input logic [TBL_BITS-1:0]  tbl,
        input logic [TBL_IDX_W-1:0] d
    );
        tbl_byte = tbl[SYM_W*d +: SYM_W];
    endfunction

endpackage

FILE: sv/sradix_dp.sv
// ----------------------------------------------------------------------------
// sradix_dp
// Datapath: configuration registers, table checker, chunked divider,
// digit stack and output register.
// ----------------------------------------------------------------------------
module sradix_dp import sradix_pkg::*; #(
    parameter int MAX_SYMBOLS = 16,
    parameter int VALUE_BITS  = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    output t_dp_sts               o_sts,
    input  logic [IN_W-1:0]       i_value,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [SYM_W-1:0]      o_symbol,
    output logic                  o_last
);

    localparam int DIG_W  = $clog2(MAX_SYMBOLS);
    localparam int PASSES = (VALUE_BITS + DIV_CHUNK - 1) / DIV_CHUNK;
    localparam int PAD_W  = PASSES * DIV_CHUNK;
    localparam int PASS_W = (PASSES > 1) ? $clog2(PASSES) : 1;
    localparam int CNT_W  = $clog2(VALUE_BITS + 1);

    logic [CFG_DATA_W-1:0] r_sym_low;
    logic [CFG_DATA_W-1:0] r_sym_high;
    logic [BASE_LEN_W-1:0] r_base_len;
    logic [TBL_BITS-1:0]   w_tbl;

    logic [TBL_IDX_W-1:0]  r_chk;
    logic [PAD_W-1:0]      r_quo;
    logic [DIG_W-1:0]      r_rem;
    logic [PASS_W-1:0]     r_pass;
    logic                  r_neg;
    logic [DIG_W-1:0]      r_stk [VALUE_BITS];
    logic [CNT_W-1:0]      r_cnt;

    logic                  r_out_valid;
    logic [SYM_W-1:0]      r_out_sym;
    logic                  r_out_last;

    logic [VALUE_BITS-1:0] w_raw;
    logic [VALUE_BITS-1:0] w_mag;
    logic                  w_chk_bad;
    logic [PAD_W-1:0]      n_quo;
    logic [DIG_W-1:0]      n_rem;
    logic                  w_out_free;
    logic                  w_div_last;

    assign w_tbl = {r_sym_high, r_sym_low};

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sym_low  <= '0;
            r_sym_high <= '0;
            r_base_len <= BASE_LEN_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SYMBOLS_LOW:  r_sym_low  <= i_cfg_data;
                CFG_SYMBOLS_HIGH: r_sym_high <= i_cfg_data;
                CFG_BASE_LEN:     r_base_len <= i_cfg_data[BASE_LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // magnitude of the input, read as a signed VALUE_BITS-bit value
    assign w_raw = i_value[VALUE_BITS-1:0];
    assign w_mag = w_raw[VALUE_BITS-1] ? (~w_raw + 1'b1) : w_raw;

    // radix range check; entry r_chk against sign bytes and earlier entries
    always_comb begin
        logic [SYM_W-1:0] b;
        b         = tbl_byte(w_tbl, r_chk);
        w_chk_bad = (r_base_len < BASE_LEN_W'(2))
                 || (r_base_len > BASE_LEN_W'(MAX_SYMBOLS))
                 || (b == PLUS_BYTE) || (b == MINUS_BYTE);
        for (int j = 0; j < TBL_ENTRIES; j++) begin
            if ((TBL_IDX_W'(j) < r_chk) && (tbl_byte(w_tbl, TBL_IDX_W'(j)) == b)) begin
                w_chk_bad = 1'b1;
            end
        end
    end

    // one chunk of restoring division by the radix
    always_comb begin
        logic [DIG_W:0]     t;
        logic [DIG_W-1:0]   rem;
        logic [DIV_CHUNK-1:0] top;
        logic [DIV_CHUNK-1:0] q;
        rem = (r_pass == '0) ? '0 : r_rem;
        top = r_quo[PAD_W-1 -: DIV_CHUNK];
        q   = '0;
        for (int k = DIV_CHUNK - 1; k >= 0; k--) begin
            t = {rem, top[k]};
            if (BASE_LEN_W'(t) >= r_base_len) begin
                t    = t - (DIG_W+1)'(r_base_len);
                q[k] = 1'b1;
            end
            rem = t[DIG_W-1:0];
        end
        n_rem = rem;
        n_quo = PAD_W'({r_quo, q});
    end

    assign w_div_last = (r_pass == PASS_W'(PASSES - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chk  <= '0;
            r_pass <= '0;
            r_cnt  <= '0;
        end else if (i_cmd.load) begin
            r_chk  <= '0;
            r_pass <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_cmd.chk_step) begin
                r_chk <= r_chk + 1'b1;
            end
            if (i_cmd.div_step) begin
                if (w_div_last) begin
                    r_pass <= '0;
                    r_cnt  <= r_cnt + 1'b1;
                end else begin
                    r_pass <= r_pass + 1'b1;
                end
            end else if (i_cmd.emit_digit) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // payload: magnitude, sign, remainder and digit stack
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_quo <= PAD_W'(w_mag);
            r_neg <= w_raw[VALUE_BITS-1];
        end else if (i_cmd.div_step) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
        if (i_cmd.div_step && w_div_last) begin
            r_stk[0] <= n_rem;
            for (int i = 1; i < VALUE_BITS; i++) begin
                r_stk[i] <= r_stk[i-1];
            end
        end else if (i_cmd.emit_digit) begin
            for (int i = 0; i < VALUE_BITS - 1; i++) begin
                r_stk[i] <= r_stk[i+1];
            end
        end
    end

    // output register
    assign w_out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_sign || i_cmd.emit_digit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_sign) begin
            r_out_sym  <= MINUS_BYTE;
            r_out_last <= 1'b0;
        end else if (i_cmd.emit_digit) begin
            r_out_sym  <= tbl_byte(w_tbl, TBL_IDX_W'(r_stk[0]));
            r_out_last <= (r_cnt == CNT_W'(1));
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_symbol    = r_out_sym;
    assign o_last      = r_out_last;

    assign o_sts.out_free   = w_out_free;
    assign o_sts.chk_bad    = w_chk_bad;
    assign o_sts.chk_done   = ({1'b0, r_chk} == (r_base_len - 1'b1));
    assign o_sts.div_last   = w_div_last;
    assign o_sts.quo_zero   = (n_quo == '0);
    assign o_sts.neg        = r_neg;
    assign o_sts.last_digit = (r_cnt == CNT_W'(1));

endmodule

FILE: sv/sradix_ctrl.sv
// ----------------------------------------------------------------------------
// sradix_ctrl
// Sequencer: table check, digit extraction, sign and digit output.
// ----------------------------------------------------------------------------
module sradix_ctrl import sradix_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_CHECK  = 3'd1;
    localparam logic [2:0] ST_DIVIDE = 3'd2;
    localparam logic [2:0] ST_SIGN   = 3'd3;
    localparam logic [2:0] ST_EMIT   = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_CHECK;
                end
            end
            ST_CHECK: begin
                // drop the item on a bad table
                priority if (i_sts.chk_bad) begin
                    n_state = ST_IDLE;
                end else if (i_sts.chk_done) begin
                    n_state = ST_DIVIDE;
                end else begin
                    o_cmd.chk_step = 1'b1;
                end
            end
            ST_DIVIDE: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last && i_sts.quo_zero) begin
                    n_state = ST_SIGN;
                end
            end
            ST_SIGN: begin
                if (!i_sts.neg) begin
                    n_state = ST_EMIT;
                end else if (i_sts.out_free) begin
                    o_cmd.emit_sign = 1'b1;
                    n_state         = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_digit = 1'b1;
                    if (i_sts.last_digit) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_in_ready = i_rst_n && (r_state == ST_IDLE);

endmodule

FILE: sv/signed_radix_to_symbols.sv
// ----------------------------------------------------------------------------
// signed_radix_to_symbols
// Converts a signed value to its digit symbols in a configured radix.
// ----------------------------------------------------------------------------
// Takes one signed value per transfer and emits its representation in radix
// base_len, most significant digit first, with a leading minus byte for
// negatives; each digit picks a byte from the 16-entry symbol table. The
// table is checked for every item (radix 2..MAX_SYMBOLS, distinct symbols,
// no plus or minus byte); an item with a bad table yields no output and ends
// in the check. One item is in work at a time. An item is taken, its table is
// checked entry by entry over the first base_len entries, and the divider,
// which retires eight quotient bits a cycle, extracts the digits onto a stack;
// a sign step then emits the minus byte for a negative value, and the digit
// symbols go out one per cycle while the output register is free. A stalled
// output holds the sequencer, and the next item is taken once the last symbol
// has gone into the output register.
// Configuration writes are taken on any cycle out of reset and must only
// occur while idle.
// ----------------------------------------------------------------------------
module signed_radix_to_symbols import sradix_pkg::*; #(
    parameter int MAX_SYMBOLS = 16,
    parameter int VALUE_BITS  = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [IN_W-1:0]       i_value,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [SYM_W-1:0]      o_symbol,
    output logic                  o_last,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    assign o_cfg_ready = i_rst_n;

    sradix_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    sradix_dp #(
        .MAX_SYMBOLS (MAX_SYMBOLS),
        .VALUE_BITS  (VALUE_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_value     (i_value),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_symbol    (o_symbol),
        .o_last      (o_last)
    );

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for signed_radix_to_symbols.
// ----------------------------------------------------------------------------
// A driver feeds signed values from a queue through the valid/ready input
// channel. At each accepted transfer a predictor expands the value into the
// symbol bytes that the current table and radix produce. A monitor compares
// every output transfer, field by field, with the oldest predicted symbol.
// The directed part covers:
//   - the reset table
//   - radix 2, 10 and 16
//   - zero and the extreme values
//   - every kind of bad table
//   - a zero-byte symbol
//   - writes to the unused register index
// Random tables and values follow, under several idle and stall mixes, with
// one long receiver hold-off.
// ----------------------------------------------------------------------------
module testbench;
    import sradix_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    localparam int SETTLE_CYCLES  = 300;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int MAX_REPORTS    = 10;
    localparam int RANDOM_ROUNDS  = 9;
    localparam int ROUND_ITEMS    = 10;

    localparam logic [CFG_DATA_W-1:0] DEC_LO = "76543210";
    localparam logic [CFG_DATA_W-1:0] DEC_HI = 64'h0000_0000_0000_3938;
    localparam logic [CFG_DATA_W-1:0] HEX_HI = "fedcba98";

    typedef struct {
        logic [SYM_W-1:0] symbol;
        logic             last;
    } sym_t;

    logic                  i_clk;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_ready;
    logic [IN_W-1:0]       i_value     = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic [SYM_W-1:0]      o_symbol;
    logic                  o_last;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    // shadow copy of the configuration registers
    logic [CFG_DATA_W-1:0] digits_lo = '0;
    logic [CFG_DATA_W-1:0] digits_hi = '0;
    logic [BASE_LEN_W-1:0] radix     = BASE_LEN_RESET;

    logic [IN_W-1:0] pending_values[$];
    sym_t            expected_symbols[$];

    int items_queued       = 0;
    int items_taken        = 0;
    int mismatches         = 0;
    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int hold_requests      = 0;
    int holds_served       = 0;
    int hold_left          = 0;
    int quiet_cycles       = 0;

    signed_radix_to_symbols DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_value     (i_value),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_symbol    (o_symbol),
        .o_last      (o_last),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [SYM_W-1:0] digit_symbol(input int d);
        logic [TBL_BITS-1:0] tbl;
        tbl = {digits_hi, digits_lo};
        return tbl[SYM_W*d +: SYM_W];
    endfunction

    // radix within 2..16, no plus or minus byte, no repeated symbol in use
    function automatic bit table_usable();
        bit [255:0]       taken;
        logic [SYM_W-1:0] b;
        if (radix < 2 || radix > TBL_ENTRIES) return 1'b0;
        taken = '0;
        taken[PLUS_BYTE]  = 1'b1;
        taken[MINUS_BYTE] = 1'b1;
        for (int i = 0; i < radix; i++) begin
            b = digit_symbol(i);
            if (taken[b]) return 1'b0;
            taken[b] = 1'b1;
        end
        return 1'b1;
    endfunction

    function automatic void predict_symbols(input logic [IN_W-1:0] v);
        logic [IN_W-1:0]      mag;
        logic [TBL_IDX_W-1:0] digs [IN_W];
        int                   nd;
        sym_t                 s;
        if (!table_usable()) return;
        // the most negative value negates to itself, which is its magnitude
        mag = v[IN_W-1] ? (~v + 1'b1) : v;
        nd  = 0;
        do begin
            digs[nd] = TBL_IDX_W'(mag % radix);
            mag      = mag / radix;
            nd++;
        end while (mag != 0);
        if (v[IN_W-1]) begin
            s.symbol = MINUS_BYTE;
            s.last   = 1'b0;
            expected_symbols.push_back(s);
        end
        while (nd > 0) begin
            nd--;
            s.symbol = digit_symbol(int'(digs[nd]));
            s.last   = (nd == 0);
            expected_symbols.push_back(s);
        end
    endfunction

    task automatic note_failure(input string what);
        mismatches++;
        if (mismatches <= MAX_REPORTS) $display("%0t ns: %s", $time, what);
    endtask

    // input driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                predict_symbols(i_value);
                items_taken++;
            end
            if (!i_in_valid || o_in_ready) begin
                if (pending_values.size() != 0 && $urandom_range(99, 0) >= sender_idle_pct) begin
                    i_in_valid <= 1'b1;
                    i_value    <= pending_values.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // output monitor
    always @(posedge i_clk) begin
        sym_t want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_symbols.size() == 0) begin
                    note_failure($sformatf("unexpected symbol 8'h%02h last %0b", o_symbol, o_last));
                end else begin
                    want = expected_symbols.pop_front();
                    if (o_symbol !== want.symbol)
                        note_failure($sformatf("symbol: expected 8'h%02h, got 8'h%02h",
                                               want.symbol, o_symbol));
                    if (o_last !== want.last)
                        note_failure($sformatf("last: expected %0b, got %0b (symbol 8'h%02h)",
                                               want.last, o_last, want.symbol));
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (holds_served < hold_requests) begin
                holds_served++;
                hold_left = HOLD_CYCLES;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99, 0) >= receiver_stall_pct);
            end
        end
    end

    // abort when no channel moves anything for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic queue_value(input logic [IN_W-1:0] v);
        pending_values.push_back(v);
        items_queued++;
    endtask

    // wait for every result, then let an item with a bad table finish
    task automatic drain();
        while (items_taken != items_queued || expected_symbols.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_SYMBOLS_LOW:  digits_lo = data;
            CFG_SYMBOLS_HIGH: digits_hi = data;
            CFG_BASE_LEN:     radix     = data[BASE_LEN_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_table(input logic [CFG_DATA_W-1:0] lo, input logic [CFG_DATA_W-1:0] hi,
                             input logic [BASE_LEN_W-1:0] len);
        logic [CFG_DATA_W-1:0] len_word;
        len_word = {$urandom, $urandom};
        len_word[BASE_LEN_W-1:0] = len;
        write_reg(CFG_SYMBOLS_LOW, lo);
        write_reg(CFG_UNUSED, {$urandom, $urandom});
        write_reg(CFG_SYMBOLS_HIGH, hi);
        write_reg(CFG_BASE_LEN, len_word);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic random_table(output logic [CFG_DATA_W-1:0] lo, output logic [CFG_DATA_W-1:0] hi,
                                output logic [BASE_LEN_W-1:0] len);
        logic [SYM_W-1:0]    bytes [TBL_ENTRIES];
        bit [255:0]          used;
        logic [TBL_BITS-1:0] flat;
        int                  j;
        used = '0;
        used[PLUS_BYTE]  = 1'b1;
        used[MINUS_BYTE] = 1'b1;
        len = ($urandom_range(7, 0) == 0) ? 5'($urandom_range(31, 0)) : 5'($urandom_range(16, 2));
        for (int i = 0; i < TBL_ENTRIES; i++) begin
            do bytes[i] = 8'($urandom_range(255, 0)); while (used[bytes[i]]);
            used[bytes[i]] = 1'b1;
        end
        // spoil one in-use symbol now and then
        if (len >= 2 && len <= TBL_ENTRIES && $urandom_range(5, 0) == 0) begin
            j = $urandom_range(len - 1, 0);
            case ($urandom_range(2, 0))
                0:       bytes[j] = PLUS_BYTE;
                1:       bytes[j] = MINUS_BYTE;
                default: bytes[j] = bytes[(j + 1) % len];
            endcase
        end
        for (int i = 0; i < TBL_ENTRIES; i++) flat[SYM_W*i +: SYM_W] = bytes[i];
        {hi, lo} = flat;
    endtask

    function automatic logic [IN_W-1:0] random_value();
        logic [IN_W-1:0] v;
        case ($urandom_range(3, 0))
            0: v = $urandom;
            1: v = $urandom_range(40, 0) - 20;
            2: begin
                v = $urandom >> $urandom_range(31, 0);
                if ($urandom_range(1, 0)) v = ~v + 1'b1;
            end
            default: begin
                case ($urandom_range(3, 0))
                    0:       v = 32'h8000_0000;
                    1:       v = 32'h7FFF_FFFF;
                    2:       v = '1;
                    default: v = '0;
                endcase
            end
        endcase
        return v;
    endfunction

    initial begin
        logic [CFG_DATA_W-1:0] tbl_lo;
        logic [CFG_DATA_W-1:0] tbl_hi;
        logic [BASE_LEN_W-1:0] tbl_len;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset table is all zero bytes: repeated symbol, nothing comes out
        queue_value(32'd5);
        queue_value(32'hFFFF_FFF6);
        drain();

        // decimal, symbols past the radix left as zero bytes
        set_table(DEC_LO, DEC_HI, 5'd10);
        queue_value(32'd0);
        queue_value(32'd1);
        queue_value(32'hFFFF_FFFF);
        queue_value(32'h7FFF_FFFF);
        queue_value(32'h8000_0000);
        queue_value(32'hFFFF_FFF6);
        queue_value(32'd123456789);
        drain();

        // binary: the most negative value gives the longest output
        sender_idle_pct = 73;
        set_table(DEC_LO, '0, 5'd2);
        queue_value(32'h8000_0000);
        queue_value(32'h7FFF_FFFF);
        queue_value(32'd0);
        drain();

        sender_idle_pct    = 0;
        receiver_stall_pct = 73;
        set_table(DEC_LO, HEX_HI, 5'd16);
        queue_value(32'hFFFF_FFFF);
        queue_value(32'hDEAD_BEEF);
        queue_value(32'h0123_4567);
        drain();

        // bad tables: radix too small or too large, plus, minus, repeated symbol
        sender_idle_pct    = 34;
        receiver_stall_pct = 34;
        for (int k = 0; k < 7; k++) begin
            case (k)
                0:       set_table(DEC_LO, '0, 5'd0);
                1:       set_table(DEC_LO, '0, 5'd1);
                2:       set_table(DEC_LO, HEX_HI, 5'd17);
                3:       set_table(DEC_LO, HEX_HI, 5'd31);
                4:       set_table("7654+210", '0, 5'd10);
                5:       set_table("-6543210", '0, 5'd8);
                default: set_table("76543211", '0, 5'd8);
            endcase
            queue_value(random_value());
            drain();
        end

        // a zero byte is an ordinary symbol
        set_table(64'h3736_3534_3332_3100, '0, 5'd8);
        queue_value(32'hFFFF_FFFB);
        queue_value(32'd64);
        drain();

        for (int round = 0; round < RANDOM_ROUNDS; round++) begin
            case (round % 4)
                0:       begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1:       begin sender_idle_pct = 73; receiver_stall_pct = 0;  end
                2:       begin sender_idle_pct = 0;  receiver_stall_pct = 73; end
                default: begin sender_idle_pct = 34; receiver_stall_pct = 34; end
            endcase
            random_table(tbl_lo, tbl_hi, tbl_len);
            set_table(tbl_lo, tbl_hi, tbl_len);
            // long receiver hold-off while the sender keeps offering
            if (round == 4) hold_requests++;
            repeat (ROUND_ITEMS) queue_value(random_value());
            drain();
        end

        if (mismatches == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule
